### rtl/height_map_fan_tessellator_unit_macros.svh
// Assertion macros used by the checker file of the fan tessellator.
`ifndef HEIGHT_MAP_FAN_TESSELLATOR_UNIT_MACROS_SVH
`define HEIGHT_MAP_FAN_TESSELLATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HMFAN_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HMFAN_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/hmfan_pkg.sv
`default_nettype none

package hmfan_pkg;

	localparam int HEIGHT_BITS = 16;
	localparam int COLOR_BITS = 16;
	localparam int IDX_W = 12;
	localparam int DIM_W = 13;
	localparam int ZS_W = 16;
	localparam int Z_W = 34;
	localparam int COLOR_OUT_W = 16;
	localparam int PAIRS = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [DIM_W-1:0] GRID_WIDTH_RST = 13'd1;
	localparam logic [DIM_W-1:0] GRID_HEIGHT_RST = 13'd1;
	localparam logic [ZS_W-1:0] Z_SCALE_RST = 16'd256;

	typedef enum logic [1:0] {
		REG_GRID_WIDTH = 2'd0,
		REG_GRID_HEIGHT = 2'd1,
		REG_Z_SCALE = 2'd2,
		REG_GRAY_MODE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0] grid_width;
		logic [DIM_W-1:0] grid_height;
		logic signed [ZS_W-1:0] z_scale;
		logic gray_mode;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// Width of one fan record in the queue: position, pair mask, last flag,
	// three columns of three heights and the center color.
	function automatic int fan_bits(int hb, int cb);
		return 2 * IDX_W + PAIRS + 1 + 9 * hb + 3 * cb;
	endfunction

endpackage

`default_nettype wire

### rtl/hmfan_in_if.sv
`default_nettype none

interface hmfan_in_if #(
	parameter int HB = hmfan_pkg::HEIGHT_BITS,
	parameter int CB = hmfan_pkg::COLOR_BITS
);
	logic valid;
	logic ready;
	logic [hmfan_pkg::IDX_W-1:0] col_index;
	logic [hmfan_pkg::IDX_W-1:0] row_index;
	logic signed [HB-1:0] height_above;
	logic signed [HB-1:0] height_here;
	logic signed [HB-1:0] height_below;
	logic [CB-1:0] red_in;
	logic [CB-1:0] green_in;
	logic [CB-1:0] blue_in;

	modport source (
		output valid, col_index, row_index, height_above, height_here, height_below,
		output red_in, green_in, blue_in,
		input ready
	);
	modport sink (
		input valid, col_index, row_index, height_above, height_here, height_below,
		input red_in, green_in, blue_in,
		output ready
	);
endinterface

`default_nettype wire

### rtl/hmfan_out_if.sv
`default_nettype none

interface hmfan_out_if;
	logic valid;
	logic ready;
	logic [hmfan_pkg::IDX_W-1:0] node_col;
	logic [hmfan_pkg::IDX_W-1:0] node_row;
	logic [2:0] tri_index;
	logic signed [hmfan_pkg::Z_W-1:0] z_first;
	logic signed [hmfan_pkg::Z_W-1:0] z_second;
	logic signed [hmfan_pkg::Z_W-1:0] z_third;
	logic [hmfan_pkg::COLOR_OUT_W-1:0] red_out;
	logic [hmfan_pkg::COLOR_OUT_W-1:0] green_out;
	logic [hmfan_pkg::COLOR_OUT_W-1:0] blue_out;
	logic last_of_run;

	modport source (
		output valid, node_col, node_row, tri_index, z_first, z_second, z_third,
		output red_out, green_out, blue_out, last_of_run,
		input ready
	);
	modport sink (
		input valid, node_col, node_row, tri_index, z_first, z_second, z_third,
		input red_out, green_out, blue_out, last_of_run,
		output ready
	);
endinterface

`default_nettype wire

### rtl/hmfan_front.sv
`default_nettype none

module hmfan_front #(
	parameter int HB = hmfan_pkg::HEIGHT_BITS,
	parameter int CB = hmfan_pkg::COLOR_BITS,
	localparam int EW = hmfan_pkg::fan_bits(HB, CB)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire hmfan_pkg::cfg_t cfg,
	hmfan_in_if.sink in_ch,
	input wire hmfan_pkg::fifo_stat_t q_stat,
	output logic push,
	output logic [EW-1:0] push_data
);

	typedef struct packed {
		logic [hmfan_pkg::IDX_W-1:0] col;
		logic [hmfan_pkg::IDX_W-1:0] row;
		logic [hmfan_pkg::PAIRS-1:0] pairs;
		logic last;
		logic [2:0][HB-1:0] lh;
		logic [2:0][HB-1:0] mh;
		logic [2:0][HB-1:0] rh;
		logic [2:0][CB-1:0] color;
	} fan_t;

	logic [2:0][HB-1:0] left_q;
	logic [2:0][HB-1:0] mid_q;
	logic [2:0][CB-1:0] mid_color_q;
	logic [2:0][HB-1:0] here;
	logic [2:0][CB-1:0] here_color;
	logic pend_q;
	fan_t pend_fan_q;
	fan_t fan_a;
	fan_t fan_b;
	logic accept;
	logic has_a;
	logic has_b;
	logic hu, hd, hl_a, hr_a, hl_b;
	logic [hmfan_pkg::DIM_W-1:0] x_ext;
	logic [hmfan_pkg::DIM_W-1:0] y_ext;

	always_comb begin
		here[0] = in_ch.height_above;
		here[1] = in_ch.height_here;
		here[2] = in_ch.height_below;
		here_color[0] = in_ch.red_in;
		here_color[1] = in_ch.green_in;
		here_color[2] = in_ch.blue_in;

		x_ext = {1'b0, in_ch.col_index};
		y_ext = {1'b0, in_ch.row_index};
		hu = (in_ch.row_index != '0);
		hd = ((y_ext + 13'd1) < cfg.grid_height);

		// Fan of the previous column's node.
		hl_a = (x_ext > 13'd1);
		hr_a = (x_ext < cfg.grid_width);
		fan_a.col = in_ch.col_index - 12'd1;
		fan_a.row = in_ch.row_index;
		fan_a.pairs = (in_ch.col_index != '0) ?
			{hd & hl_a, hd & hr_a, hu & hr_a, hu & hl_a} : '0;
		fan_a.lh = left_q;
		fan_a.mh = mid_q;
		fan_a.rh = here;
		fan_a.color = mid_color_q;

		// Fan of this node, only on the last column; it has no right side.
		hl_b = (in_ch.col_index != '0);
		fan_b.col = in_ch.col_index;
		fan_b.row = in_ch.row_index;
		fan_b.pairs = ((x_ext + 13'd1) == cfg.grid_width) ?
			{hd & hl_b, 1'b0, 1'b0, hu & hl_b} : '0;
		fan_b.last = 1'b1;
		fan_b.lh = mid_q;
		fan_b.mh = here;
		fan_b.rh = here;
		fan_b.color = here_color;

		has_a = (fan_a.pairs != '0);
		has_b = (fan_b.pairs != '0);
		fan_a.last = !has_b;

		in_ch.ready = !pend_q && !q_stat.full;
		accept = in_ch.valid && in_ch.ready;

		push = 1'b0;
		push_data = fan_a;
		if (pend_q) begin
			push = !q_stat.full;
			push_data = pend_fan_q;
		end else if (accept && has_a) begin
			push = 1'b1;
			push_data = fan_a;
		end else if (accept && has_b) begin
			push = 1'b1;
			push_data = fan_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (pend_q && !q_stat.full) begin
			pend_q <= 1'b0;
		end else if (accept && has_a && has_b) begin
			pend_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			left_q <= mid_q;
			mid_q <= here;
			mid_color_q <= here_color;
			if (has_a && has_b) begin
				pend_fan_q <= fan_b;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/hmfan_fifo.sv
`default_nettype none

module hmfan_fifo #(
	parameter int W = 8,
	parameter int DEPTH = hmfan_pkg::QUEUE_DEPTH,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [W-1:0] wr_data,
	input wire logic pop,
	output logic [W-1:0] rd_data,
	output hmfan_pkg::fifo_stat_t stat
);

	logic [W-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rd_data = mem[rd_ptr_q];
	assign stat.full = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

### rtl/hmfan_back.sv
`default_nettype none

module hmfan_back #(
	parameter int HB = hmfan_pkg::HEIGHT_BITS,
	parameter int CB = hmfan_pkg::COLOR_BITS,
	localparam int EW = hmfan_pkg::fan_bits(HB, CB)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire hmfan_pkg::cfg_t cfg,
	input wire hmfan_pkg::fifo_stat_t q_stat,
	input wire logic [EW-1:0] head_data,
	output logic pop,
	hmfan_out_if.source out_ch
);

	localparam int SW = HB + 2;
	localparam int PW = hmfan_pkg::ZS_W + SW;

	typedef struct packed {
		logic [hmfan_pkg::IDX_W-1:0] col;
		logic [hmfan_pkg::IDX_W-1:0] row;
		logic [hmfan_pkg::PAIRS-1:0] pairs;
		logic last;
		logic [2:0][HB-1:0] lh;
		logic [2:0][HB-1:0] mh;
		logic [2:0][HB-1:0] rh;
		logic [2:0][CB-1:0] color;
	} fan_t;

	fan_t head;
	logic [hmfan_pkg::PAIRS-1:0] done_q;
	logic half_q;
	logic [hmfan_pkg::PAIRS-1:0] rem;
	logic [hmfan_pkg::PAIRS-1:0] rest;
	logic [1:0] cur_pair;
	logic final_pair;
	logic issue;
	logic s1_ready;
	logic s2_load;
	logic [2:0] tri_cur;
	logic [2:0] tri_next;
	logic signed [SW-1:0] ls [3];
	logic signed [SW-1:0] ms [3];
	logic signed [SW-1:0] rs [3];
	logic signed [SW-1:0] ring [8];

	logic s1_v;
	logic [hmfan_pkg::IDX_W-1:0] col_s1;
	logic [hmfan_pkg::IDX_W-1:0] row_s1;
	logic [2:0] tri_s1;
	logic signed [SW-1:0] z1s_s1;
	logic signed [SW-1:0] z2s_s1;
	logic signed [SW-1:0] z3s_s1;
	logic [hmfan_pkg::COLOR_OUT_W-1:0] red_s1;
	logic [hmfan_pkg::COLOR_OUT_W-1:0] green_s1;
	logic [hmfan_pkg::COLOR_OUT_W-1:0] blue_s1;
	logic last_s1;

	logic signed [PW-1:0] prod1;
	logic signed [PW-1:0] prod2;
	logic signed [PW-1:0] prod3;

	logic out_v_q;
	logic [hmfan_pkg::IDX_W-1:0] col_q;
	logic [hmfan_pkg::IDX_W-1:0] row_q;
	logic [2:0] tri_q;
	logic signed [hmfan_pkg::Z_W-1:0] z1_q;
	logic signed [hmfan_pkg::Z_W-1:0] z2_q;
	logic signed [hmfan_pkg::Z_W-1:0] z3_q;
	logic [hmfan_pkg::COLOR_OUT_W-1:0] red_q;
	logic [hmfan_pkg::COLOR_OUT_W-1:0] green_q;
	logic [hmfan_pkg::COLOR_OUT_W-1:0] blue_q;
	logic last_q;

	// Triangle sequencer: walks the set pairs of the head fan, two triangles
	// per pair, and pops the fan after the second triangle of its last pair.
	always_comb begin
		head = fan_t'(head_data);
		rem = head.pairs & ~done_q;
		if (rem[0]) begin
			cur_pair = 2'd0;
		end else if (rem[1]) begin
			cur_pair = 2'd1;
		end else if (rem[2]) begin
			cur_pair = 2'd2;
		end else begin
			cur_pair = 2'd3;
		end
		rest = rem & ~(4'b0001 << cur_pair);
		final_pair = (rest == '0);
		tri_cur = {cur_pair, half_q};
		tri_next = tri_cur + 3'd1;

		s2_load = !out_v_q || out_ch.ready;
		s1_ready = !s1_v || s2_load;
		issue = !q_stat.empty && s1_ready;
		pop = issue && half_q && final_pair;

		for (int i = 0; i < 3; i++) begin
			ls[i] = SW'($signed(head.lh[i]));
			ms[i] = SW'($signed(head.mh[i]));
			rs[i] = SW'($signed(head.rh[i]));
		end

		// Vertex height sums around the node, starting to the left and going
		// over the top; triangle t uses entries t and t+1, wrapping from entry 7 to entry 0.
		ring[0] = (ls[1] + ms[1]) <<< 1;
		ring[1] = ls[0] + ls[1] + ms[0] + ms[1];
		ring[2] = (ms[0] + ms[1]) <<< 1;
		ring[3] = ms[0] + ms[1] + rs[0] + rs[1];
		ring[4] = (ms[1] + rs[1]) <<< 1;
		ring[5] = ms[1] + ms[2] + rs[1] + rs[2];
		ring[6] = (ms[1] + ms[2]) <<< 1;
		ring[7] = ls[1] + ls[2] + ms[1] + ms[2];

		prod1 = $signed(cfg.z_scale) * z1s_s1;
		prod2 = $signed(cfg.z_scale) * z2s_s1;
		prod3 = $signed(cfg.z_scale) * z3s_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
			half_q <= 1'b0;
			s1_v <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (issue) begin
				half_q <= !half_q;
				if (half_q) begin
					done_q <= final_pair ? '0 : (done_q | (4'b0001 << cur_pair));
				end
			end
			if (s1_ready) begin
				s1_v <= issue;
			end
			if (s2_load) begin
				out_v_q <= s1_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			col_s1 <= head.col;
			row_s1 <= head.row;
			tri_s1 <= tri_cur;
			z1s_s1 <= ms[1] <<< 2;
			z2s_s1 <= ring[tri_cur];
			z3s_s1 <= ring[tri_next];
			red_s1 <= hmfan_pkg::COLOR_OUT_W'(head.color[0]);
			green_s1 <= hmfan_pkg::COLOR_OUT_W'(cfg.gray_mode ? head.color[0] : head.color[1]);
			blue_s1 <= hmfan_pkg::COLOR_OUT_W'(cfg.gray_mode ? head.color[0] : head.color[2]);
			last_s1 <= head.last && final_pair && half_q;
		end
		if (s2_load && s1_v) begin
			col_q <= col_s1;
			row_q <= row_s1;
			tri_q <= tri_s1;
			z1_q <= hmfan_pkg::Z_W'(prod1);
			z2_q <= hmfan_pkg::Z_W'(prod2);
			z3_q <= hmfan_pkg::Z_W'(prod3);
			red_q <= red_s1;
			green_q <= green_s1;
			blue_q <= blue_s1;
			last_q <= last_s1;
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.node_col = col_q;
	assign out_ch.node_row = row_q;
	assign out_ch.tri_index = tri_q;
	assign out_ch.z_first = z1_q;
	assign out_ch.z_second = z2_q;
	assign out_ch.z_third = z3_q;
	assign out_ch.red_out = red_q;
	assign out_ch.green_out = green_q;
	assign out_ch.blue_out = blue_q;
	assign out_ch.last_of_run = last_q;

endmodule

`default_nettype wire

### rtl/height_map_fan_tessellator_unit.sv
// Throughput: one triangle per cycle while the receiver is ready; an item that yields two fans
// holds the input until its second fan is queued, and a full queue stalls the input.
// Reset (arst_n low, asynchronous): handshake and sequencer state clear, registers return
// to width 1, height 1, scale 1.0, color mode; the stored columns stay undefined.
`default_nettype none

module height_map_fan_tessellator_unit #(
	parameter int HEIGHT_BITS = hmfan_pkg::HEIGHT_BITS,
	parameter int COLOR_BITS = hmfan_pkg::COLOR_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [hmfan_pkg::APB_ADDR_W-1:0] paddr,
	input wire logic [hmfan_pkg::APB_DATA_W-1:0] pwdata,
	output logic [hmfan_pkg::APB_DATA_W-1:0] prdata,
	output logic pready,
	hmfan_in_if.sink in_ch,
	hmfan_out_if.source out_ch
);

	// One queue record carries a whole fan: where the node is, which of its
	// four triangle pairs lie inside the grid, the three height columns
	// around it and its color.
	localparam int EW = hmfan_pkg::fan_bits(HEIGHT_BITS, COLOR_BITS);

	hmfan_pkg::cfg_t cfg_q;
	hmfan_pkg::reg_idx_t reg_idx;
	hmfan_pkg::fifo_stat_t q_stat;
	logic cfg_wr;
	logic push;
	logic pop;
	logic [EW-1:0] push_data;
	logic [EW-1:0] head_data;

	// Configuration port. Writes land on the access phase; there are no wait
	// states. The registers are to be written only while the block is idle; the block does not enforce this.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign reg_idx = hmfan_pkg::reg_idx_t'(paddr[hmfan_pkg::APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width <= hmfan_pkg::GRID_WIDTH_RST;
			cfg_q.grid_height <= hmfan_pkg::GRID_HEIGHT_RST;
			cfg_q.z_scale <= hmfan_pkg::Z_SCALE_RST;
			cfg_q.gray_mode <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				hmfan_pkg::REG_GRID_WIDTH: begin
					cfg_q.grid_width <= pwdata[hmfan_pkg::DIM_W-1:0];
				end
				hmfan_pkg::REG_GRID_HEIGHT: begin
					cfg_q.grid_height <= pwdata[hmfan_pkg::DIM_W-1:0];
				end
				hmfan_pkg::REG_Z_SCALE: begin
					cfg_q.z_scale <= pwdata[hmfan_pkg::ZS_W-1:0];
				end
				hmfan_pkg::REG_GRAY_MODE: begin
					cfg_q.gray_mode <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			hmfan_pkg::REG_GRID_WIDTH: begin
				prdata = hmfan_pkg::APB_DATA_W'(cfg_q.grid_width);
			end
			hmfan_pkg::REG_GRID_HEIGHT: begin
				prdata = hmfan_pkg::APB_DATA_W'(cfg_q.grid_height);
			end
			hmfan_pkg::REG_Z_SCALE: begin
				prdata = hmfan_pkg::APB_DATA_W'(unsigned'(cfg_q.z_scale));
			end
			hmfan_pkg::REG_GRAY_MODE: begin
				prdata = hmfan_pkg::APB_DATA_W'(cfg_q.gray_mode);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// Front end: takes one column item per cycle unless the queue is full or a second fan
	// is pending, keeps the two previous columns and turns each item into at most two fan
	// records (the fan of the previous node and, on the last column, the fan of this node).
	hmfan_front #(
		.HB(HEIGHT_BITS),
		.CB(COLOR_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_ch(in_ch),
		.q_stat(q_stat),
		.push(push),
		.push_data(push_data)
	);

	// Fan queue: lets the front keep taking items while the back end is
	// still emitting the triangles of earlier fans.
	hmfan_fifo #(
		.W(EW),
		.DEPTH(hmfan_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_data(push_data),
		.pop(pop),
		.rd_data(head_data),
		.stat(q_stat)
	);

	// Back end: one triangle per cycle while the receiver is ready, vertex sums in the first
	// stage and the scale multiply into the output register in the second.
	hmfan_back #(
		.HB(HEIGHT_BITS),
		.CB(COLOR_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_stat(q_stat),
		.head_data(head_data),
		.pop(pop),
		.out_ch(out_ch)
	);

endmodule

`default_nettype wire

### rtl/hmfan_checker.sv
`include "height_map_fan_tessellator_unit_macros.svh"
`default_nettype none

module hmfan_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [hmfan_pkg::IDX_W-1:0] out_node_col,
	input wire logic [2:0] out_tri,
	input wire logic [hmfan_pkg::Z_W-1:0] out_z_first,
	input wire logic out_last
);

	// A stalled result must stay offered, with its column, triangle index and first height unchanged.
	`HMFAN_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "out item dropped while stalled")
	`HMFAN_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_tri) && $stable(out_z_first) && $stable(out_node_col), "out item changed while stalled")

	// Triangles come in pairs, so the last one of an item has an odd index.
	`HMFAN_ASSERT_IMP(a_last_odd, clk, arst_n, out_valid && !out_tri[0], !out_last, "last item on even triangle")

	// The center vertex is four times the scaled height.
	`HMFAN_ASSERT_IMP(a_center_x4, clk, arst_n, out_valid, out_z_first[1:0] == 2'b00, "center height not a multiple of four")

endmodule

bind height_map_fan_tessellator_unit hmfan_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_node_col(out_ch.node_col),
	.out_tri(out_ch.tri_index),
	.out_z_first(out_ch.z_first),
	.out_last(out_ch.last_of_run)
);

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import hmfan_pkg::*;

	// One grid column as the sender offers it.
	typedef struct packed {
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] row;
		logic signed [HEIGHT_BITS-1:0] above;
		logic signed [HEIGHT_BITS-1:0] here;
		logic signed [HEIGHT_BITS-1:0] below;
		logic [COLOR_BITS-1:0] red;
		logic [COLOR_BITS-1:0] green;
		logic [COLOR_BITS-1:0] blue;
	} column_t;

	// One triangle record as the block emits it.
	typedef struct packed {
		logic [IDX_W-1:0] node_col;
		logic [IDX_W-1:0] node_row;
		logic [2:0] tri_index;
		logic signed [Z_W-1:0] z_first;
		logic signed [Z_W-1:0] z_second;
		logic signed [Z_W-1:0] z_third;
		logic [COLOR_OUT_W-1:0] red_out;
		logic [COLOR_OUT_W-1:0] green_out;
		logic [COLOR_OUT_W-1:0] blue_out;
		logic last_of_run;
	} triangle_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	hmfan_in_if in_ch ();
	hmfan_out_if out_ch ();

	height_map_fan_tessellator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Our own copy of the registers and of the two stored columns. The block
	// leaves its stored columns undefined after reset, so the stimulus always
	// starts at column 0 and never lets a fan read a column not yet sent.
	cfg_t shadow_cfg;
	column_t left_column;
	column_t middle_column;

	// Triangles still owed by the block, oldest first.
	triangle_t tri_expect_q[$];

	int error_count = 0;
	int items_sent = 0;
	int burst_left = 0;
	bit sender_bursty = 1'b1;
	bit sink_free = 1'b0;
	int hold_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs or loses triangles.
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report_error(string what);
		error_count++;
		if (error_count <= 10) begin
			$display("ERROR at %0t ns: %s", $time, what);
		end
	endtask

	function automatic string describe_triangle(triangle_t t);
		return $sformatf("node(%0d,%0d) tri %0d z %0d/%0d/%0d rgb %h/%h/%h last %b",
			t.node_col, t.node_row, t.tri_index, $signed(t.z_first), $signed(t.z_second),
			$signed(t.z_third), t.red_out, t.green_out, t.blue_out, t.last_of_run);
	endfunction

	function automatic longint hgt(logic signed [HEIGHT_BITS-1:0] v);
		return longint'(v);
	endfunction

	// Queues one triangle. Gray mode is taken from the shadow registers when the triangle is
	// predicted, while the block applies the register value current when the fan goes out.
	function automatic void expect_triangle(logic [IDX_W-1:0] col, logic [IDX_W-1:0] row,
			logic [2:0] idx, longint z1, longint z2, longint z3, column_t center);
		triangle_t t;
		t.node_col = col;
		t.node_row = row;
		t.tri_index = idx;
		t.z_first = z1[Z_W-1:0];
		t.z_second = z2[Z_W-1:0];
		t.z_third = z3[Z_W-1:0];
		t.red_out = center.red;
		t.green_out = shadow_cfg.gray_mode ? center.red : center.green;
		t.blue_out = shadow_cfg.gray_mode ? center.red : center.blue;
		t.last_of_run = 1'b0;
		tri_expect_q.push_back(t);
	endfunction

	// Fan around one node. lc, mc and rc are the columns left of, at and right
	// of the node. Vertex heights are the mean of one, two or four samples
	// scaled by z_scale; with 10 fraction bits the sums come out exact.
	function automatic void expect_fan(logic [IDX_W-1:0] col, logic [IDX_W-1:0] row,
			bit has_l, bit has_r, bit has_u, bit has_d,
			column_t lc, column_t mc, column_t rc, column_t center);
		longint zs, zoo, zmo, zpo, zom, zop, zmm, zpm, zpp, zmp;
		zs = longint'($signed(shadow_cfg.z_scale));
		zoo = 4 * zs * hgt(mc.here);
		zmo = 2 * zs * (hgt(lc.here) + hgt(mc.here));
		zpo = 2 * zs * (hgt(mc.here) + hgt(rc.here));
		zom = 2 * zs * (hgt(mc.above) + hgt(mc.here));
		zop = 2 * zs * (hgt(mc.here) + hgt(mc.below));
		zmm = zs * (hgt(lc.above) + hgt(lc.here) + hgt(mc.above) + hgt(mc.here));
		zpm = zs * (hgt(mc.above) + hgt(mc.here) + hgt(rc.above) + hgt(rc.here));
		zpp = zs * (hgt(mc.here) + hgt(mc.below) + hgt(rc.here) + hgt(rc.below));
		zmp = zs * (hgt(lc.here) + hgt(lc.below) + hgt(mc.here) + hgt(mc.below));
		if (has_u && has_l) begin
			expect_triangle(col, row, 3'd0, zoo, zmo, zmm, center);
			expect_triangle(col, row, 3'd1, zoo, zmm, zom, center);
		end
		if (has_u && has_r) begin
			expect_triangle(col, row, 3'd2, zoo, zom, zpm, center);
			expect_triangle(col, row, 3'd3, zoo, zpm, zpo, center);
		end
		if (has_d && has_r) begin
			expect_triangle(col, row, 3'd4, zoo, zpo, zpp, center);
			expect_triangle(col, row, 3'd5, zoo, zpp, zop, center);
		end
		if (has_d && has_l) begin
			expect_triangle(col, row, 3'd6, zoo, zop, zmp, center);
			expect_triangle(col, row, 3'd7, zoo, zmp, zmo, center);
		end
	endfunction

	// Works out every triangle one accepted column causes, then shifts the
	// column into the stored pair. The fan of column x-1 comes first; at the
	// last column the fan of column x follows, with nothing to its right.
	function automatic void predict_column(column_t c);
		int x, y, w, h, first;
		bit up, down;
		column_t blank;
		triangle_t tail;
		x = int'(c.col);
		y = int'(c.row);
		w = int'(shadow_cfg.grid_width);
		h = int'(shadow_cfg.grid_height);
		up = (y > 0);
		down = (y + 1 < h);
		blank = '0;
		first = tri_expect_q.size();
		if (x >= 1) begin
			expect_fan(c.col - 1'b1, c.row, x > 1, x < w, up, down,
				left_column, middle_column, c, middle_column);
		end
		if (x + 1 == w) begin
			expect_fan(c.col, c.row, x > 0, 1'b0, up, down, middle_column, c, blank, c);
		end
		if (tri_expect_q.size() > first) begin
			tail = tri_expect_q.pop_back();
			tail.last_of_run = 1'b1;
			tri_expect_q.push_back(tail);
		end
		left_column = middle_column;
		middle_column = c;
	endfunction

	function automatic logic [HEIGHT_BITS-1:0] pick_height();
		case ($urandom_range(0, 7))
			0: return {1'b1, {(HEIGHT_BITS-1){1'b0}}};
			1: return {1'b0, {(HEIGHT_BITS-1){1'b1}}};
			default: return HEIGHT_BITS'($urandom);
		endcase
	endfunction

	function automatic column_t make_column(int x, int y, int above, int here, int below,
			int r, int g, int b);
		column_t c;
		c.col = IDX_W'(x);
		c.row = IDX_W'(y);
		c.above = HEIGHT_BITS'(above);
		c.here = HEIGHT_BITS'(here);
		c.below = HEIGHT_BITS'(below);
		c.red = COLOR_BITS'(r);
		c.green = COLOR_BITS'(g);
		c.blue = COLOR_BITS'(b);
		return c;
	endfunction

	function automatic column_t random_column(int x, int y);
		return make_column(x, y, int'(pick_height()), int'(pick_height()),
			int'(pick_height()), int'($urandom), int'($urandom), int'($urandom));
	endfunction

	// Offers one column and waits for it to be taken. In bursty mode the
	// sender may drop valid between bursts of random length.
	task automatic send_column(column_t c);
		int gap;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 10);
			gap = sender_bursty ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.col_index <= c.col;
		in_ch.row_index <= c.row;
		in_ch.height_above <= c.above;
		in_ch.height_here <= c.here;
		in_ch.height_below <= c.below;
		in_ch.red_in <= c.red;
		in_ch.green_in <= c.green;
		in_ch.blue_in <= c.blue;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_column(c);
		items_sent++;
	endtask

	// Stops offering and waits until every triangle owed has come out, then
	// gives the block a few cycles to finish items that yield nothing.
	task automatic wait_for_drain();
		in_ch.valid <= 1'b0;
		while (tri_expect_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_GRID_WIDTH: shadow_cfg.grid_width = value[DIM_W-1:0];
			REG_GRID_HEIGHT: shadow_cfg.grid_height = value[DIM_W-1:0];
			REG_Z_SCALE: shadow_cfg.z_scale = value[ZS_W-1:0];
			REG_GRAY_MODE: shadow_cfg.gray_mode = value[0];
		endcase
	endtask

	task automatic configure_grid(int w, int h, int zs, bit gray);
		wait_for_drain();
		write_register(REG_GRID_WIDTH, APB_DATA_W'(w));
		write_register(REG_GRID_HEIGHT, APB_DATA_W'(h));
		write_register(REG_Z_SCALE, APB_DATA_W'(zs[ZS_W-1:0]));
		write_register(REG_GRAY_MODE, APB_DATA_W'(gray));
	endtask

	// Streams a grid in raster order. Small grids go out whole; for large
	// dimensions only a window at the far edge (or the first rows) is sent so
	// the border logic is hit without long rows. Noise columns with random
	// positions are slipped in now and then to break the sequence.
	task automatic send_grid(int w, int h, int noise_pct);
		int x0, y0, y1;
		x0 = (w > 12) ? w - $urandom_range(2, 5) : 0;
		y0 = 0;
		y1 = h - 1;
		if (h > 8) begin
			y0 = ($urandom_range(0, 1) != 0) ? 0 : h - 3;
			y1 = y0 + 2;
		end
		for (int y = y0; y <= y1; y++) begin
			for (int x = x0; x < w; x++) begin
				if ($urandom_range(1, 100) <= noise_pct) begin
					send_column(random_column($urandom_range(0, 4095), $urandom_range(0, 4095)));
				end
				send_column(random_column(x, y));
			end
		end
	endtask

	// Reset values: a one-by-one grid has no triangles at all, even for a
	// column index past the grid width.
	task automatic test_reset_defaults();
		send_column(random_column(0, 0));
		send_column(random_column(1, 0));
		send_column(random_column(0, 0));
	endtask

	// Extreme heights, colors and scales, every triangle of a full fan, the
	// last row and column of the largest grid, out-of-range column indexes,
	// gray mode, and a width of zero where no column ever counts as last.
	task automatic test_directed_extremes();
		configure_grid(3, 3, -32768, 1'b0);
		for (int y = 0; y < 3; y++) begin
			for (int x = 0; x < 3; x++) begin
				send_column(make_column(x, y, -32768, ((x + y) % 2) ? 32767 : -32768, 32767,
					(x % 2) ? 0 : 16'hFFFF, 16'h8001, 16'h7FFE));
			end
		end
		send_column(make_column(4095, 1, 32767, -32768, 32767, 16'h0000, 16'hFFFF, 16'h1234));
		send_column(make_column(0, 4095, -32768, 32767, -32768, 16'hFFFF, 16'h0000, 16'hA5A5));

		configure_grid(4096, 4096, 32767, 1'b1);
		send_column(make_column(4093, 4095, 32767, 32767, -32768, 16'hFFFF, 16'h0000, 16'h0001));
		send_column(make_column(4094, 4095, -32768, 32767, 32767, 16'h8000, 16'h1111, 16'h2222));
		send_column(make_column(4095, 4095, 32767, -32768, 32767, 16'h0001, 16'hFFFF, 16'h3333));
		send_column(make_column(0, 0, 32767, 32767, 32767, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_column(make_column(1, 0, -32768, -32768, -32768, 16'h0000, 16'h0000, 16'h0000));

		configure_grid(0, 2, 256, 1'b0);
		send_column(random_column(0, 0));
		send_column(random_column(1, 0));
		send_column(random_column(2, 0));
	endtask

	// Random grid shapes and register settings, each streamed with random
	// content and occasional noise columns.
	task automatic test_random_grids();
		int w, h, zs;
		while (items_sent < 200) begin
			case ($urandom_range(0, 9))
				0: w = 1;
				1, 2: w = $urandom_range(13, 4096);
				default: w = $urandom_range(2, 7);
			endcase
			h = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 4096) : $urandom_range(1, 5);
			case ($urandom_range(0, 5))
				0: zs = -32768;
				1: zs = 32767;
				2: zs = 0;
				3: zs = 256;
				default: zs = int'($urandom_range(0, 65535)) - 32768;
			endcase
			configure_grid(w, h, zs, $urandom_range(0, 1));
			sender_bursty = ($urandom_range(0, 3) != 0);
			send_grid(w, h, ($urandom_range(0, 3) == 0) ? 0 : 12);
		end
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering, so the block's queue fills and its input stalls. Then the
	// sender pauses until all triangles are out, and a stretch follows with
	// neither side idling.
	task automatic test_backpressure();
		configure_grid(8, 5, 384, 1'b0);
		sender_bursty = 1'b0;
		hold_cycles = 150;
		send_grid(8, 5, 0);
		wait_for_drain();
		sink_free = 1'b1;
		send_grid(8, 2, 0);
		sink_free = 1'b0;
		sender_bursty = 1'b1;
	endtask

	// Receiver: its duty cycle changes after spans of random length, from always
	// ready down to mostly stalled, independent of what the sender does.
	initial begin : sink_pattern
		int duty;
		int span;
		duty = 100;
		span = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (span == 0) begin
				span = $urandom_range(8, 40);
				case ($urandom_range(0, 3))
					0: duty = 100;
					1: duty = 70;
					2: duty = 40;
					default: duty = 15;
				endcase
			end
			span--;
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ch.ready <= 1'b0;
			end else if (sink_free) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= ($urandom_range(1, 100) <= duty);
			end
		end
	end

	// Every triangle taken by the receiver is matched against the oldest one
	// owed. Values are sampled at the clock edge, before any update from it.
	initial begin : triangle_checker
		triangle_t want;
		triangle_t got;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				got.node_col = out_ch.node_col;
				got.node_row = out_ch.node_row;
				got.tri_index = out_ch.tri_index;
				got.z_first = out_ch.z_first;
				got.z_second = out_ch.z_second;
				got.z_third = out_ch.z_third;
				got.red_out = out_ch.red_out;
				got.green_out = out_ch.green_out;
				got.blue_out = out_ch.blue_out;
				got.last_of_run = out_ch.last_of_run;
				if (tri_expect_q.size() == 0) begin
					report_error({"unexpected triangle ", describe_triangle(got)});
				end else begin
					want = tri_expect_q.pop_front();
					if (got !== want) begin
						report_error({"triangle mismatch, expected ", describe_triangle(want),
							", got ", describe_triangle(got)});
					end
				end
			end
		end
	end

	initial begin : main_sequence
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.col_index <= '0;
		in_ch.row_index <= '0;
		in_ch.height_above <= '0;
		in_ch.height_here <= '0;
		in_ch.height_below <= '0;
		in_ch.red_in <= '0;
		in_ch.green_in <= '0;
		in_ch.blue_in <= '0;
		shadow_cfg.grid_width = GRID_WIDTH_RST;
		shadow_cfg.grid_height = GRID_HEIGHT_RST;
		shadow_cfg.z_scale = Z_SCALE_RST;
		shadow_cfg.gray_mode = 1'b0;
		left_column = '0;
		middle_column = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_directed_extremes();
		test_random_grids();
		test_backpressure();

		// Let the last triangles out, bounded, then allow a few extra cycles
		// so any stray output is still caught.
		in_ch.valid <= 1'b0;
		for (int n = 0; n < 5000 && tri_expect_q.size() != 0; n++) @(posedge clk);
		repeat (8) @(posedge clk);
		if (tri_expect_q.size() != 0) begin
			report_error($sformatf("%0d triangles never arrived", tri_expect_q.size()));
		end

		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/hmfan_pkg.sv
rtl/hmfan_in_if.sv
rtl/hmfan_out_if.sv
rtl/hmfan_front.sv
rtl/hmfan_fifo.sv
rtl/hmfan_back.sv
rtl/height_map_fan_tessellator_unit.sv
rtl/hmfan_checker.sv
bench/tb_top.sv
